// File: hw/rtl/sobel_edge_magnitude_rgb_assert.svh
// Assertion macros for the Sobel edge block.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SEM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SEM_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SEM_ASSERT(label, clk, rst, prop, msg)
`define SEM_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: hw/rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge block.
`timescale 1ns / 1ps
package sem_pkg;
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int DIM_W = 11;
   localparam int PIX_W = 24;
   localparam int SUM_W = 21;
   localparam logic [DIM_W-1:0] WIDTH_RESET = 11'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;
   localparam logic CSR_FRAME_WIDTH = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [7:0] EDGE_MAX = 8'd255;

   typedef struct packed {
      logic line_end;
      logic frame_end;
   } job_ctl_type;
endpackage

// File: hw/rtl/sem_front.sv
// Front: frame position tracking, line store and 3x3 window build.
`timescale 1ns / 1ps
module sem_front #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic csr_index,
   input  logic [sem_pkg::DIM_W-1:0] csr_value,
   input  logic in_valid,
   output logic in_stall,
   input  logic in_kind,
   input  logic [sem_pkg::PIX_W-1:0] in_pix,
   output logic job_valid,
   input  logic job_stall,
   output logic [sem_pkg::PIX_W*9-1:0] job_win,
   output sem_pkg::job_ctl_type job_ctl
);
   import sem_pkg::*;
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 3);
   localparam int AW = $clog2(MAX_WIDTH);

   logic [CW-1:0] width_ff, width_in;
   logic [RW-1:0] height_ff, height_in;
   logic [CW-1:0] icol_ff, icol_in, ocol_ff, ocol_in;
   logic [RW-1:0] irow_ff, irow_in, orow_ff, orow_in;
   logic [PIX_W-1:0] line0 [MAX_WIDTH];
   logic [PIX_W-1:0] line1 [MAX_WIDTH];
   logic [PIX_W-1:0] rd0_ff, rd1_ff;
   logic [PIX_W-1:0] mid_ff [3];
   logic [PIX_W-1:0] col_ff [3];
   logic [PIX_W-1:0] cur_pix;
   logic stage_ff, stage_in;
   logic [CW-1:0] scol_ff;
   logic sfirst_ff;
   logic [PIX_W-1:0] spix_ff;
   logic out_ff;
   logic [PIX_W*9-1:0] job_win_ff;
   job_ctl_type job_ctl_ff;
   logic take, draining, emit;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int mx);
      if (v == '0) return DIM_W'(1);
      if (int'(v) > mx) return DIM_W'(mx);
      return v;
   endfunction

   assign draining = irow_ff >= height_ff;
   assign in_stall = stage_ff | (out_ff & job_stall);
   assign take = in_valid & ~in_stall & (~in_kind | draining);
   assign cur_pix = draining ? '0 : in_pix;

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      icol_in = icol_ff;
      irow_in = irow_ff;
      stage_in = 1'b0;
      if (take) begin
         stage_in = 1'b1;
         if (icol_ff == width_ff - CW'(1)) begin
            icol_in = '0;
            irow_in = irow_ff + RW'(1);
         end else begin
            icol_in = icol_ff + CW'(1);
         end
      end
      if (emit && ocol_ff == width_ff - CW'(1) && orow_ff == height_ff - RW'(1)) begin
         icol_in = '0;
         irow_in = '0;
      end
      if (csr_write) begin
         if (csr_index == CSR_FRAME_WIDTH)
            width_in = CW'(clamp_dim(csr_value, MAX_WIDTH));
         else
            height_in = RW'(clamp_dim(csr_value, MAX_HEIGHT));
         icol_in = '0;
         irow_in = '0;
      end
   end

   // item index >= w+1 means row>=1 and not (row==1 && col==0)
   assign emit = stage_ff & sfirst_ff;
   assign ocol_in = emit ? ((ocol_ff == width_ff - CW'(1)) ? '0 : ocol_ff + CW'(1)) : ocol_ff;
   assign orow_in = emit ? ((ocol_ff == width_ff - CW'(1)) ?
                    ((orow_ff == height_ff - RW'(1)) ? '0 : orow_ff + RW'(1)) : orow_ff)
                    : orow_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         rd0_ff <= line0[icol_ff[AW-1:0]];
         rd1_ff <= line1[icol_ff[AW-1:0]];
         line0[icol_ff[AW-1:0]] <= cur_pix;
         spix_ff <= cur_pix;
         scol_ff <= icol_ff;
         sfirst_ff <= (irow_ff > RW'(1)) || (irow_ff == RW'(1) && icol_ff != '0);
      end
      if (stage_ff) line1[scol_ff[AW-1:0]] <= rd0_ff;
   end

   // new column: ncol[0]=row-2 (top), [1]=row-1, [2]=row (new)
   logic [PIX_W-1:0] ncol [3];
   logic [PIX_W-1:0] nwin [9];
   logic lft, rgt, top, bot;
   always_comb begin
      ncol[0] = rd1_ff;
      ncol[1] = rd0_ff;
      ncol[2] = spix_ff;
      lft = ocol_ff == '0;
      rgt = ocol_ff == width_ff - CW'(1);
      top = orow_ff == '0;
      bot = orow_ff == height_ff - RW'(1);
      for (int r = 0; r < 3; r++) begin
         nwin[r*3+0] = col_ff[r];
         nwin[r*3+1] = mid_ff[r];
         nwin[r*3+2] = ncol[r];
      end
      for (int r = 0; r < 3; r++) begin
         if (lft) nwin[r*3+0] = '0;
         if (rgt) nwin[r*3+2] = '0;
      end
      if (top) begin
         nwin[0] = '0; nwin[1] = '0; nwin[2] = '0;
      end
      if (bot) begin
         nwin[6] = '0; nwin[7] = '0; nwin[8] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CW'(WIDTH_RESET);
         height_ff <= RW'(HEIGHT_RESET);
         icol_ff <= '0;
         irow_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
         stage_ff <= 1'b0;
         out_ff <= 1'b0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         icol_ff <= icol_in;
         irow_ff <= irow_in;
         ocol_ff <= csr_write ? '0 : ocol_in;
         orow_ff <= csr_write ? '0 : orow_in;
         stage_ff <= stage_in;
         if (emit) out_ff <= 1'b1;
         else if (!job_stall) out_ff <= 1'b0;
      end
      if (stage_ff) begin
         for (int r = 0; r < 3; r++) begin
            col_ff[r] <= mid_ff[r];
            mid_ff[r] <= ncol[r];
         end
      end
      if (emit) begin
         for (int k = 0; k < 9; k++) job_win_ff[k*PIX_W +: PIX_W] <= nwin[k];
         job_ctl_ff.line_end <= rgt;
         job_ctl_ff.frame_end <= rgt & bot;
      end
   end

   assign job_valid = out_ff;
   assign job_win = job_win_ff;
   assign job_ctl = job_ctl_ff;
endmodule

// File: hw/rtl/sem_back.sv
// Back: per-channel Sobel gradient, squared sum and rounded root.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_rgb_assert.svh"
module sem_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_stall,
   input  logic [sem_pkg::PIX_W*9-1:0] job_win,
   input  sem_pkg::job_ctl_type job_ctl,
   output logic out_valid,
   input  logic out_stall,
   output logic [7:0] out_blue,
   output logic [7:0] out_green,
   output logic [7:0] out_red,
   output logic out_line_end,
   output logic out_frame_end
);
   import sem_pkg::*;
   typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT, S_OUT} state_type;
   state_type state_ff;
   logic [SUM_W-1:0] s_ff [3];
   logic [10:0] ax_ff [3], ay_ff [3];
   logic [8:0] r_ff [3];
   logic [3:0] bit_ff;
   logic le_ff, fe_ff;
   logic [7:0] e_ff [3];
   logic ov_ff;
   logic le_o_ff, fe_o_ff;
   logic fire;

   function automatic logic signed [11:0] px(input logic [PIX_W*9-1:0] w,
                                            input int k, input int ch);
      return 12'(w[k*PIX_W + ch*8 +: 8]);
   endfunction

   assign job_stall = state_ff != S_IDLE;
   // result register is free or drains this cycle
   assign fire = (state_ff == S_OUT) && !(ov_ff && out_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         if (fire) ov_ff <= 1'b1;
         else if (!out_stall) ov_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (job_valid) begin
               for (int c = 0; c < 3; c++) begin
                  logic signed [11:0] gx, gy;
                  gx = (px(job_win,2,c) + 12'sd2*px(job_win,5,c) + px(job_win,8,c))
                     - (px(job_win,0,c) + 12'sd2*px(job_win,3,c) + px(job_win,6,c));
                  gy = (px(job_win,6,c) + 12'sd2*px(job_win,7,c) + px(job_win,8,c))
                     - (px(job_win,0,c) + 12'sd2*px(job_win,1,c) + px(job_win,2,c));
                  ax_ff[c] <= gx[11] ? 11'(-gx) : 11'(gx);
                  ay_ff[c] <= gy[11] ? 11'(-gy) : 11'(gy);
               end
               le_ff <= job_ctl.line_end;
               fe_ff <= job_ctl.frame_end;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               for (int c = 0; c < 3; c++) begin
                  s_ff[c] <= SUM_W'(32'(ax_ff[c])*32'(ax_ff[c]) + 32'(ay_ff[c])*32'(ay_ff[c]));
                  r_ff[c] <= '0;
               end
               bit_ff <= 4'd8;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               // bitwise search for r with r*r - r < s, r <= 511
               for (int c = 0; c < 3; c++) begin
                  logic [8:0] t;
                  t = r_ff[c] | (9'd1 << bit_ff);
                  if (SUM_W'(t)*SUM_W'(t) - SUM_W'(t) < s_ff[c]) r_ff[c] <= t;
               end
               if (bit_ff == '0) state_ff <= S_OUT;
               else bit_ff <= bit_ff - 4'd1;
            end
            S_OUT: if (fire) begin
               for (int c = 0; c < 3; c++)
                  e_ff[c] <= r_ff[c][8] ? EDGE_MAX : r_ff[c][7:0];
               le_o_ff <= le_ff;
               fe_o_ff <= fe_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign out_valid = ov_ff;
   assign out_blue = e_ff[0];
   assign out_green = e_ff[1];
   assign out_red = e_ff[2];
   assign out_line_end = le_o_ff;
   assign out_frame_end = fe_o_ff;

   `SEM_ASSERT(a_fe_le, clock, reset, !(out_valid && out_frame_end && !out_line_end), "frame end without line end")
   `SEM_ASSERT(a_busy, clock, reset, (job_valid && state_ff == S_IDLE) |=> state_ff == S_SQ, "job not taken")
   `SEM_ASSERT(a_hold, clock, reset, (out_valid && out_stall) |=> (out_valid && $stable(out_blue)), "stalled result changed")
endmodule

// File: hw/rtl/sobel_edge_magnitude_rgb.sv
// Top level of the streaming RGB Sobel edge magnitude block.
//  channel  dir  handshake          payload
//  req      in   req_valid/stall    kind, blue_in, green_in, red_in
//  rsp      out  rsp_valid/stall    blue/green/red_edge, line_end, frame_end
//  csr      in   csr_valid/ready    csr_index, csr_data
// An item passes the front's line store read and then its window shift; the front takes
// no new item while one is in the shift step. A result holds the back for one gradient,
// one square, nine root bit steps and one clamp; it takes one job at a time, so a new job
// waits for the clamp. rsp_valid rises once the releasing item has passed all these steps.
// Reset is synchronous; the line store has no reset and is written before read.
// Stall on rsp holds the back's result, then backs up into the front and req_stall.
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_kind,
   input  logic [7:0] req_blue_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_red_in,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_blue_edge,
   output logic [7:0] rsp_green_edge,
   output logic [7:0] rsp_red_edge,
   output logic rsp_line_end,
   output logic rsp_frame_end,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [0:0] csr_index,
   input  logic [sem_pkg::DIM_W-1:0] csr_data
);
   import sem_pkg::*;
   logic job_valid, job_stall;
   logic [PIX_W*9-1:0] job_win;
   job_ctl_type job_ctl;

   assign csr_ready = 1'b1;

   sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock, .reset,
      .csr_write(csr_valid), .csr_index(csr_index[0]), .csr_value(csr_data),
      .in_valid(req_valid), .in_stall(req_stall), .in_kind(req_kind),
      .in_pix({req_red_in, req_green_in, req_blue_in}),
      .job_valid, .job_stall, .job_win, .job_ctl
   );

   sem_back u_back (
      .clock, .reset, .job_valid, .job_stall, .job_win, .job_ctl,
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_blue(rsp_blue_edge), .out_green(rsp_green_edge), .out_red(rsp_red_edge),
      .out_line_end(rsp_line_end), .out_frame_end(rsp_frame_end)
   );
endmodule

// File: tb/tb_sobel_edge_magnitude_rgb.sv
// Self-checking testbench for the streaming RGB Sobel edge magnitude block.
`timescale 1ns / 1ps
module tb_sobel_edge_magnitude_rgb;
   import sem_pkg::*;

   localparam int RING = 2 * MAX_WIDTH_DEF + 4;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE = 40;

   typedef struct {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic line_end;
      logic frame_end;
   } edge_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = 1'b0;
   logic [7:0] req_blue_in = '0;
   logic [7:0] req_green_in = '0;
   logic [7:0] req_red_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_blue_edge, rsp_green_edge, rsp_red_edge;
   logic rsp_line_end, rsp_frame_end;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = '0;
   logic [DIM_W-1:0] csr_data = '0;

   sobel_edge_magnitude_rgb u_top (.*);

   // predictor state
   logic [PIX_W-1:0] hist [0:RING-1];
   int slot, in_col, in_row, out_col, out_row, fw, fh;
   edge_beat_type edge_q[$];

   int errors = 0;
   int cycles = 0;
   int sent = 0;
   int got = 0;
   int frames = 0;
   bit quiet = 1'b0;
   int stall_left = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats pending", cycles, edge_q.size());
         $display("[sobel_edge_magnitude_rgb] ERROR");
         $finish;
      end
   end

   task automatic report(string what, int seen, int want);
      $display("mismatch on %s at result %0d: got %0d expected %0d", what, got, seen, want);
      errors++;
   endtask

   function automatic void restart_frame();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function automatic int fit_dim(logic [DIM_W-1:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic logic [7:0] mag(int w[9]);
      int gx, gy, s, r;
      gx = (w[2] + 2 * w[5] + w[8]) - (w[0] + 2 * w[3] + w[6]);
      gy = (w[6] + 2 * w[7] + w[8]) - (w[0] + 2 * w[1] + w[2]);
      s = gx * gx + gy * gy;
      r = 0;
      while (r <= 256 && (r + 1) * (r + 1) <= s) r++;
      if (s > r * r + r) r++;
      if (r > 255) r = 255;
      return r[7:0];
   endfunction

   function automatic void predict_edges(logic kind, logic [7:0] b, logic [7:0] g,
                                         logic [7:0] r);
      bit drain;
      int item, rr, cc, back, k;
      logic [PIX_W-1:0] win [9];
      int cb[9], cg[9], cr[9];
      edge_beat_type e;
      drain = in_row >= fh;
      if (kind && !drain) return;
      item = in_row * fw + in_col;
      hist[slot] = drain ? '0 : {r, g, b};
      in_col++;
      if (in_col >= fw) begin
         in_col = 0;
         in_row++;
      end
      if (item < fw + 1) begin
         slot = (slot + 1) % RING;
         return;
      end
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            rr = out_row + dr;
            cc = out_col + dc;
            k = (dr + 1) * 3 + dc + 1;
            win[k] = '0;
            if (rr >= 0 && rr < fh && cc >= 0 && cc < fw) begin
               back = fw + 1 - dr * fw - dc;
               win[k] = hist[(slot + RING - back) % RING];
            end
            cb[k] = int'(win[k][7:0]);
            cg[k] = int'(win[k][15:8]);
            cr[k] = int'(win[k][23:16]);
         end
      end
      e.blue = mag(cb);
      e.green = mag(cg);
      e.red = mag(cr);
      e.line_end = (out_col == fw - 1);
      e.frame_end = e.line_end && out_row == fh - 1;
      edge_q.push_back(e);
      slot = (slot + 1) % RING;
      if (e.frame_end) begin
         restart_frame();
      end else begin
         out_col++;
         if (out_col >= fw) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   always @(posedge clock) begin
      edge_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (edge_q.size() == 0) begin
            report("unexpected beat", 1, 0);
         end else begin
            e = edge_q.pop_front();
            if (rsp_blue_edge !== e.blue)
               report("blue_edge", int'(rsp_blue_edge), int'(e.blue));
            if (rsp_green_edge !== e.green)
               report("green_edge", int'(rsp_green_edge), int'(e.green));
            if (rsp_red_edge !== e.red)
               report("red_edge", int'(rsp_red_edge), int'(e.red));
            if (rsp_line_end !== e.line_end)
               report("line_end", int'(rsp_line_end), int'(e.line_end));
            if (rsp_frame_end !== e.frame_end)
               report("frame_end", int'(rsp_frame_end), int'(e.frame_end));
            if (e.frame_end) frames++;
         end
         got++;
      end
   end

   always @(negedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = int'($urandom_range(0, 3));
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(logic kind, logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_blue_in <= b;
      req_green_in <= g;
      req_red_in <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predict_edges(kind, b, g, r);
      sent++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = int'($urandom_range(1, 4));
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_pixel();
      send_item(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
   endtask

   task automatic send_flush();
      send_item(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (edge_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [DIM_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      if (idx == CSR_FRAME_WIDTH) fw = fit_dim(data, MAX_WIDTH_DEF);
      else fh = fit_dim(data, MAX_HEIGHT_DEF);
      restart_frame();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
   endtask

   // one frame of random pixels; noise adds ignored flushes and extra drain pixels
   task automatic random_frame(bit noise);
      for (int i = 0; i < fw * fh; i++) begin
         if (noise && $urandom_range(0, 9) == 0) send_flush();
         send_pixel();
      end
      for (int i = 0; i <= fw; i++) begin
         if (noise && $urandom_range(0, 3) == 0) send_pixel();
         else send_flush();
      end
   endtask

   task automatic test_extremes();
      set_frame(11'd1, 11'd1);
      send_item(1'b0, 8'hFF, 8'h00, 8'hFF);
      send_flush();
      send_flush();
      set_frame(11'd3, 11'd2);
      for (int i = 0; i < 6; i++)
         send_item(1'b0, i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF, 8'hFF);
      for (int i = 0; i < 4; i++) send_flush();
      set_frame(11'd0, 11'd0);
      send_item(1'b0, 8'h00, 8'h00, 8'h00);
      send_flush();
      send_flush();
   endtask

   task automatic test_special_cases();
      set_frame(11'd2, 11'd2);
      send_pixel();
      send_flush();
      send_pixel();
      send_pixel();
      send_flush();
      send_pixel();
      send_pixel();
      send_flush();
      send_pixel();
      // restart in the middle of a frame
      set_frame(11'd3, 11'd3);
      send_pixel();
      send_pixel();
      send_pixel();
      send_pixel();
      wait_idle();
      write_reg(CSR_FRAME_HEIGHT, 11'd2);
      random_frame(1'b0);
   endtask

   task automatic test_wide_frame();
      set_frame(11'h7FF, 11'd1);
      for (int i = 0; i < 24; i++) send_pixel();
      set_frame(11'd2, 11'h7FF);
      for (int i = 0; i < 8; i++) send_pixel();
      wait_idle();
      write_reg(CSR_FRAME_HEIGHT, 11'd2);
      random_frame(1'b0);
   endtask

   task automatic test_random_frames();
      int stop;
      stop = sent + 760;
      while (sent < stop) begin
         set_frame(DIM_W'($urandom_range(1, 9)), DIM_W'($urandom_range(1, 6)));
         if (sent > stop - 120) quiet = 1'b1;
         if ($urandom_range(0, 7) == 0) begin
            for (int i = int'($urandom_range(1, fw * fh)); i > 0; i--) send_pixel();
         end else begin
            random_frame($urandom_range(0, 2) == 0);
         end
      end
   endtask

   initial begin
      fw = int'(WIDTH_RESET);
      fh = int'(HEIGHT_RESET);
      slot = 0;
      restart_frame();
      for (int i = 0; i < RING; i++) hist[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_special_cases();
      test_wide_frame();
      test_random_frames();
      wait_idle();
      $display("sent %0d input beats, checked %0d result beats over %0d frames",
               sent, got, frames);
      $display("frames from 1x1 to 9x6, clamped sizes, ignored flushes, drain pixels, restarts");
      if (errors == 0) begin
         $display("[sobel_edge_magnitude_rgb] OK");
      end else begin
         $display("[sobel_edge_magnitude_rgb] ERROR");
      end
      $finish;
   end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/sem_pkg.sv
hw/rtl/sem_front.sv
hw/rtl/sem_back.sv
hw/rtl/sobel_edge_magnitude_rgb.sv
tb/tb_sobel_edge_magnitude_rgb.sv
